// File: rtl/sliding_window_inversion_counter_defines.svh
// Assertion macros for the sliding window inversion counter
`ifndef SLIDING_WINDOW_INVERSION_COUNTER_DEFINES_SVH
`define SLIDING_WINDOW_INVERSION_COUNTER_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define SWIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("swic assertion failed");

// consequent checked in the same cycle
`define SWIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("swic assertion failed");

`endif

// File: rtl/swic_pkg.sv
// Shared types and constants of the sliding window inversion counter
package swic_pkg;

  localparam int TREE_SIZE = 1024;
  localparam int POSITIONS = 1024;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 10;
  localparam int RANK_W   = 11;
  localparam int NODE_W   = 11;
  localparam int COUNT_W  = 19;
  localparam int LIMIT_W  = 11;

  localparam int TREE_AW = $clog2(TREE_SIZE);
  localparam int POS_AW  = $clog2(POSITIONS);
  // tree index 0..TREE_SIZE, plus headroom for idx + lowbit(idx)
  localparam int IDX_W   = TREE_AW + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD      = 3'd0,
    ACT_ADD_LEFT  = 3'd1,
    ACT_ADD_RIGHT = 3'd2,
    ACT_REM_LEFT  = 3'd3,
    ACT_REM_RIGHT = 3'd4
  } action_e;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic              adding;
    logic              left_end;
  } tree_req_t;

  typedef struct packed {
    logic               clearing;
    logic               done;
    logic [COUNT_W-1:0] term;
  } tree_sts_t;

endpackage

// File: rtl/sliding_window_inversion_counter.sv
// Top level: command port, rank store and window pair count
//
// After reset the block runs a clearing pass over the 1024-node count tree
// and holds busy_o high while it runs; value_limit writes are taken
// meanwhile. An item is transferred when start_i is high and busy_o low.
// A load, an unknown action, or an edit whose stored rank is out of range
// gives its result in ST_DONE, by way of ST_RANK. An edit reads the stored
// rank in ST_RANK, walks the tree upward, and then runs one prefix walk
// (left end) or two (right end) before the result; every walk visits one
// node at a time through the single read port of the tree RAM.
// done_o marks the result for exactly one cycle; the receiver cannot hold
// it off, and busy_o drops in the following cycle.
module sliding_window_inversion_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [swic_pkg::ACTION_W-1:0] action_i,
  input  logic [swic_pkg::POS_W-1:0]    position_i,
  input  logic [swic_pkg::RANK_W-1:0]   rank_i,
  input  logic                         value_limit_we_i,
  input  logic [swic_pkg::LIMIT_W-1:0]  value_limit_i,
  output logic                         done_o,
  output logic [swic_pkg::COUNT_W-1:0]  inversion_count_o
);
  import swic_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RANK = 4'b0010,
    ST_TREE = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [COUNT_W-1:0] pair_q, pair_d;
  logic [ACTION_W-1:0] action_q;
  logic               pos_ok_q;

  logic               accept;
  logic               pos_ok;
  logic               is_edit;
  logic               adding;
  logic               rank_ok;
  logic [RANK_W-1:0]  store_rdata;
  tree_req_t          tree_req;
  tree_sts_t          tree_sts;

  assign accept  = start_i && !busy_o;
  assign pos_ok  = 32'(position_i) < POSITIONS;
  assign is_edit = action_q inside {ACT_ADD_LEFT, ACT_ADD_RIGHT, ACT_REM_LEFT, ACT_REM_RIGHT};
  assign adding  = (action_q == ACT_ADD_LEFT) || (action_q == ACT_ADD_RIGHT);
  assign rank_ok = pos_ok_q && (store_rdata != '0) && (32'(store_rdata) <= TREE_SIZE);

  swic_ram #(
    .WIDTH(RANK_W),
    .DEPTH(POSITIONS)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (action_i == ACT_LOAD) && pos_ok),
    .waddr_i(POS_AW'(position_i)),
    .wdata_i(rank_i),
    .raddr_i(POS_AW'(position_i)),
    .rdata_o(store_rdata)
  );

  swic_tree_engine u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tree_req),
    .limit_i(limit_q),
    .sts_o  (tree_sts)
  );

  always_comb begin
    state_d           = state_q;
    pair_d            = pair_q;
    tree_req.valid    = 1'b0;
    tree_req.rank     = store_rdata;
    tree_req.adding   = adding;
    tree_req.left_end = (action_q == ACT_ADD_LEFT) || (action_q == ACT_REM_LEFT);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        // store read data is valid here
        if (is_edit && rank_ok) begin
          tree_req.valid = 1'b1;
          state_d        = ST_TREE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_TREE: begin
        if (tree_sts.done) begin
          pair_d  = adding ? (pair_q + tree_sts.term) : (pair_q - tree_sts.term);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pair_q  <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      state_q <= state_d;
      pair_q  <= pair_d;
      if (value_limit_we_i) begin
        limit_q <= value_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      pos_ok_q <= pos_ok;
    end
  end

  assign busy_o            = (state_q != ST_IDLE) || tree_sts.clearing;
  assign done_o            = (state_q == ST_DONE);
  assign inversion_count_o = pair_q;

endmodule

// File: rtl/swic_ram.sv
// Generic single write port RAM with one registered read port
module swic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/swic_tree_engine.sv
// Fenwick tree engine: clear pass, update walk and prefix walks over one RAM
module swic_tree_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swic_pkg::tree_req_t         req_i,
  input  logic [swic_pkg::LIMIT_W-1:0] limit_i,
  output swic_pkg::tree_sts_t         sts_o
);
  import swic_pkg::*;

  typedef enum logic [3:0] {
    TE_CLEAR = 4'b0001,
    TE_IDLE  = 4'b0010,
    TE_UPD   = 4'b0100,
    TE_PRE   = 4'b1000
  } te_state_e;

  te_state_e          state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   rank_q, rank_d;
  logic [TREE_AW-1:0] wr_addr_q, wr_addr_d;
  logic [TREE_AW-1:0] clr_q, clr_d;
  logic [COUNT_W-1:0] acc_q, acc_d;
  logic               pend_q, pend_d;
  logic               neg_q, neg_d;
  logic               second_q, second_d;
  logic               inc_q, inc_d;
  logic               left_q, left_d;

  logic               mem_we;
  logic [TREE_AW-1:0] mem_waddr;
  logic [NODE_W-1:0]  mem_wdata;
  logic [TREE_AW-1:0] mem_raddr;
  logic [NODE_W-1:0]  mem_rdata;

  logic [IDX_W-1:0]   lowbit;
  logic [IDX_W-1:0]   limit_idx;
  logic               walk_end;

  swic_ram #(
    .WIDTH(NODE_W),
    .DEPTH(TREE_SIZE)
  ) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign lowbit    = idx_q & (~idx_q + IDX_W'(1));
  assign limit_idx = (32'(limit_i) > TREE_SIZE) ? IDX_W'(TREE_SIZE) : IDX_W'(limit_i);
  assign walk_end  = (idx_q == '0) && !pend_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rank_d    = rank_q;
    wr_addr_d = wr_addr_q;
    clr_d     = clr_q;
    acc_d     = acc_q;
    pend_d    = pend_q;
    neg_d     = neg_q;
    second_d  = second_q;
    inc_d     = inc_q;
    left_d    = left_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = inc_q ? (mem_rdata + NODE_W'(1)) : (mem_rdata - NODE_W'(1));
    mem_raddr = TREE_AW'(idx_q - IDX_W'(1));
    sts_o     = '{clearing: 1'b0, done: 1'b0, term: acc_q};

    case (state_q)
      TE_CLEAR: begin
        sts_o.clearing = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + TREE_AW'(1);
        if (32'(clr_q) == TREE_SIZE - 1) begin
          state_d = TE_IDLE;
        end
      end
      TE_IDLE: begin
        pend_d = 1'b0;
        if (req_i.valid) begin
          rank_d  = IDX_W'(req_i.rank);
          idx_d   = IDX_W'(req_i.rank);
          inc_d   = req_i.adding;
          left_d  = req_i.left_end;
          state_d = TE_UPD;
        end
      end
      TE_UPD: begin
        // write back the node read last cycle while reading the next one
        mem_we = pend_q;
        if (32'(idx_q) <= TREE_SIZE) begin
          wr_addr_d = TREE_AW'(idx_q - IDX_W'(1));
          idx_d     = idx_q + lowbit;
          pend_d    = 1'b1;
        end else begin
          pend_d   = 1'b0;
          acc_d    = '0;
          neg_d    = 1'b0;
          second_d = !left_q;
          idx_d    = left_q ? (rank_q - IDX_W'(1)) : limit_idx;
          state_d  = TE_PRE;
        end
      end
      TE_PRE: begin
        if (pend_q) begin
          acc_d = neg_q ? (acc_q - COUNT_W'(mem_rdata)) : (acc_q + COUNT_W'(mem_rdata));
        end
        pend_d = (idx_q != '0);
        if (idx_q != '0) begin
          idx_d = idx_q - lowbit;
        end
        if (walk_end) begin
          if (second_q) begin
            idx_d    = rank_q;
            neg_d    = 1'b1;
            second_d = 1'b0;
          end else begin
            sts_o.done = 1'b1;
            state_d    = TE_IDLE;
          end
        end
      end
      default: begin
        state_d = TE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= TE_CLEAR;
      clr_q    <= '0;
      pend_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    rank_q    <= rank_d;
    wr_addr_q <= wr_addr_d;
    acc_q     <= acc_d;
    neg_q     <= neg_d;
    inc_q     <= inc_d;
    left_q    <= left_d;
  end

endmodule

// File: rtl/swic_checker.sv
// Port-level checker for the sliding window inversion counter, bound to the top
`include "sliding_window_inversion_counter_defines.svh"

module swic_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [swic_pkg::ACTION_W-1:0] action_i,
  input logic                         done_o,
  input logic [swic_pkg::COUNT_W-1:0]  inversion_count_o
);
  import swic_pkg::*;

  // a transfer makes the block busy
  `SWIC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // a result ends the item: ready again in the next cycle
  `SWIC_ASSERT_NEXT(a_done_free, clk_i, rst_ni, done_o, !busy_o && !done_o)
  // no result without an item in flight
  `SWIC_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  // count holds while nothing is transferred
  `SWIC_ASSERT_NEXT(a_idle_hold, clk_i, rst_ni, !busy_o && !start_i, $stable(inversion_count_o))
  // a load never moves the count
  `SWIC_ASSERT_NEXT(a_load_hold, clk_i, rst_ni, start_i && !busy_o && (action_i == ACT_LOAD), $stable(inversion_count_o))

endmodule

bind sliding_window_inversion_counter swic_checker u_swic_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .action_i         (action_i),
  .done_o           (done_o),
  .inversion_count_o(inversion_count_o)
);

// File: tb/tb_top.sv
// Testbench for the sliding window inversion counter: directed table, random windows, scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swic_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;
  localparam int IDLE_LIMIT   = 20000;
  localparam int TARGET_ITEMS = 1700;
  localparam int N_ROWS       = 25;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // for ROW_CFG rows the value field carries the new value_limit
  typedef struct packed {
    row_kind_e             kind;
    logic [ACTION_W-1:0]   act;
    logic [POS_W-1:0]      pos;
    logic [RANK_W-1:0]     value;
    bit                    typed;
    logic [COUNT_W-1:0]    count;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [ACTION_W-1:0] action_i;
  logic [POS_W-1:0]    position_i;
  logic [RANK_W-1:0]   rank_i;
  logic                value_limit_we_i;
  logic [LIMIT_W-1:0]  value_limit_i;
  logic                done_o;
  logic [COUNT_W-1:0]  inversion_count_o;

  // shadow state of the block
  logic [NODE_W-1:0]  rank_tree [1:TREE_SIZE];
  logic [RANK_W-1:0]  stored_rank [POSITIONS];
  logic [COUNT_W-1:0] pair_total;
  logic [LIMIT_W-1:0] limit_reg;

  logic [COUNT_W-1:0] expected_counts [$];
  logic [COUNT_W-1:0] want_count;
  int                 mismatches;
  int                 items_sent;
  int                 idle_cycles;
  stim_row_t          directed_rows [N_ROWS];

  sliding_window_inversion_counter u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .action_i          (action_i),
    .position_i        (position_i),
    .rank_i            (rank_i),
    .value_limit_we_i  (value_limit_we_i),
    .value_limit_i     (value_limit_i),
    .done_o            (done_o),
    .inversion_count_o (inversion_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [COUNT_W-1:0] tree_prefix_sum(int unsigned idx);
    logic [COUNT_W-1:0] sum;
    int unsigned        i;
    sum = '0;
    i = (idx > TREE_SIZE) ? TREE_SIZE : idx;
    while (i > 0) begin
      sum += COUNT_W'(rank_tree[i]);
      i -= i & (~i + 1);
    end
    return sum;
  endfunction

  function automatic void tree_update(int unsigned idx, bit adding);
    int unsigned i;
    i = idx;
    while (i >= 1 && i <= TREE_SIZE) begin
      rank_tree[i] = adding ? rank_tree[i] + 1'b1 : rank_tree[i] - 1'b1;
      i += i & (~i + 1);
    end
  endfunction

  // advances the shadow state by one item and returns the new pair count
  function automatic logic [COUNT_W-1:0] next_inversion_count(logic [ACTION_W-1:0] act,
                                                              logic [POS_W-1:0] pos,
                                                              logic [RANK_W-1:0] rnk);
    int unsigned        v;
    bit                 adding;
    bit                 left_end;
    logic [COUNT_W-1:0] term;
    if (act == ACT_LOAD) begin
      stored_rank[pos] = rnk;
    end else if (act <= ACT_REM_RIGHT) begin
      v = stored_rank[pos];
      if (v >= 1 && v <= TREE_SIZE) begin
        adding   = (act == ACT_ADD_LEFT) || (act == ACT_ADD_RIGHT);
        left_end = (act == ACT_ADD_LEFT) || (act == ACT_REM_LEFT);
        tree_update(v, adding);
        if (left_end) begin
          term = tree_prefix_sum(v - 1);
        end else begin
          term = tree_prefix_sum(limit_reg) - tree_prefix_sum(v);
        end
        pair_total = adding ? pair_total + term : pair_total - term;
      end
    end
    return pair_total;
  endfunction

  task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] want);
    $display("ERROR %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic int random_rank(int top_rank);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(TREE_SIZE + 1, 2047);
    if (r < 11) return $urandom_range(1, TREE_SIZE);  // may exceed value_limit
    return $urandom_range(1, top_rank);
  endfunction

  // start_i stays high across back-to-back transfers; only lowered for a gap or while waiting for all results
  task automatic send_item(logic [ACTION_W-1:0] act, int pos, int rnk, bit typed,
                           logic [COUNT_W-1:0] typed_count, int gap);
    logic [COUNT_W-1:0] predicted;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    action_i   <= act;
    position_i <= POS_W'(pos);
    rank_i     <= RANK_W'(rnk);
    do @(posedge clk_i); while (busy_o);
    predicted = next_inversion_count(act, POS_W'(pos), RANK_W'(rnk));
    expected_counts = {expected_counts, (typed ? typed_count : predicted)};
    if (act <= ACT_REM_RIGHT) items_sent++;
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_counts.size() != 0 || busy_o);
  endtask

  task automatic write_value_limit(logic [LIMIT_W-1:0] v);
    value_limit_we_i <= 1'b1;
    value_limit_i    <= v;
    @(posedge clk_i);
    value_limit_we_i <= 1'b0;
    limit_reg = v;
  endtask

  // set value_limit, load a stretch of the array, then walk a window over it with stray items mixed in
  task automatic run_window_phase();
    logic [LIMIT_W-1:0]  lim;
    logic [ACTION_W-1:0] act;
    logic [ACTION_W-1:0] moves [$];
    int top_rank, span, base, lo, hi, n_ops, r, p;
    bit quiet;
    quiet = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 10) lim = LIMIT_W'(1);
    else if (r < 15) lim = LIMIT_W'(2);
    else if (r < 30) lim = LIMIT_W'(TREE_SIZE);
    else if (r < 35) lim = LIMIT_W'($urandom_range(TREE_SIZE + 1, 2047));
    else if (r < 37) lim = '0;
    else lim = LIMIT_W'($urandom_range(3, TREE_SIZE - 1));
    wait_all_results();
    write_value_limit(lim);
    top_rank = (lim == 0 || lim > TREE_SIZE) ? TREE_SIZE : int'(lim);
    span = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(4, 40);
    base = $urandom_range(0, POSITIONS - span);
    for (int i = 0; i < span; i++) begin
      send_item(ACT_LOAD, base + i, random_rank(top_rank), 1'b0, '0, pick_gap(quiet));
    end
    lo = base + $urandom_range(0, span);
    hi = lo;
    n_ops = 2 * span + $urandom_range(10, 40);
    for (int k = 0; k < n_ops; k++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(base, base + span - 1);
      if (r < 4) begin
        send_item(ACTION_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI)),
                  $urandom_range(0, 1023), $urandom_range(0, 2047), 1'b0, '0,
                  pick_gap(quiet));
      end else if (r < 9) begin
        // edit that breaks the window bookkeeping
        send_item(ACTION_W'($urandom_range(ACT_ADD_LEFT, ACT_REM_RIGHT)), p,
                  $urandom_range(0, 2047), 1'b0, '0, pick_gap(quiet));
      end else if (r < 11) begin
        send_item(ACT_LOAD, p, random_rank(top_rank), 1'b0, '0, pick_gap(quiet));
      end else begin
        moves.delete();
        if (hi < base + span) moves = {moves, ACT_ADD_RIGHT};
        if (lo > base) moves = {moves, ACT_ADD_LEFT};
        if (hi > lo) begin
          moves = {moves, ACT_REM_LEFT};
          moves = {moves, ACT_REM_RIGHT};
        end
        act = moves[$urandom_range(0, moves.size() - 1)];
        case (act)
          ACT_ADD_RIGHT: begin
            p = hi;
            hi++;
          end
          ACT_ADD_LEFT: begin
            lo--;
            p = lo;
          end
          ACT_REM_LEFT: begin
            p = lo;
            lo++;
          end
          default: begin
            hi--;
            p = hi;
          end
        endcase
        send_item(act, p, $urandom_range(0, 2047), 1'b0, '0, pick_gap(quiet));
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      while (lo < hi) begin
        send_item(ACT_REM_LEFT, lo, $urandom_range(0, 2047), 1'b0, '0, pick_gap(quiet));
        lo++;
      end
    end
  endtask

  // scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected result", inversion_count_o, '0);
      end else begin
        want_count = expected_counts.pop_front();
        if (inversion_count_o !== want_count) begin
          report_mismatch("inversion_count", inversion_count_o, want_count);
        end
      end
    end
  end

  // watchdog: no transfer and no result for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    action_i         = ACT_LOAD;
    position_i       = '0;
    rank_i           = '0;
    value_limit_we_i = 1'b0;
    value_limit_i    = '0;
    mismatches       = 0;
    items_sent       = 0;
    idle_cycles      = 0;
    pair_total       = '0;
    limit_reg        = LIMIT_RESET;
    for (int i = 1; i <= TREE_SIZE; i++) rank_tree[i] = '0;
    for (int i = 0; i < POSITIONS; i++) stored_rank[i] = '0;

    directed_rows = '{
      '{ROW_ITEM, ACT_LOAD,       10'd0,    11'd1,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_LOAD,       10'd1023, 11'd1024, 1'b1, 19'd0},
      '{ROW_ITEM, ACT_LOAD,       10'd1,    11'd2047, 1'b1, 19'd0},
      '{ROW_ITEM, ACT_LOAD,       10'd2,    11'd0,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_LOAD,       10'd3,    11'd512,  1'b1, 19'd0},
      '{ROW_ITEM, ACT_UNKNOWN_LO, 10'd0,    11'd0,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_UNKNOWN_HI, 10'd1023, 11'd2047, 1'b1, 19'd0},
      '{ROW_ITEM, ACT_ADD_RIGHT,  10'd0,    11'd0,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_ADD_RIGHT,  10'd3,    11'd0,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_ADD_LEFT,   10'd1023, 11'd0,    1'b1, 19'd2},
      '{ROW_ITEM, ACT_ADD_RIGHT,  10'd1,    11'd0,    1'b1, 19'd2},
      '{ROW_ITEM, ACT_ADD_LEFT,   10'd2,    11'd0,    1'b1, 19'd2},
      '{ROW_ITEM, ACT_REM_LEFT,   10'd1023, 11'd0,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_REM_RIGHT,  10'd3,    11'd0,    1'b1, 19'd0},
      '{ROW_ITEM, ACT_REM_LEFT,   10'd0,    11'd0,    1'b1, 19'd0},
      // limit above the tree size is clamped in the prefix walk
      '{ROW_CFG,  ACT_LOAD,       10'd0,    11'd2047, 1'b0, 19'd0},
      '{ROW_ITEM, ACT_ADD_RIGHT,  10'd3,    11'd0,    1'b0, 19'd0},
      '{ROW_ITEM, ACT_ADD_RIGHT,  10'd0,    11'd0,    1'b0, 19'd0},
      // zero limit: greater-than term wraps
      '{ROW_CFG,  ACT_LOAD,       10'd0,    11'd0,    1'b0, 19'd0},
      '{ROW_ITEM, ACT_REM_RIGHT,  10'd0,    11'd0,    1'b0, 19'd0},
      '{ROW_ITEM, ACT_ADD_RIGHT,  10'd1023, 11'd0,    1'b0, 19'd0},
      '{ROW_CFG,  ACT_LOAD,       10'd0,    11'd1024, 1'b0, 19'd0},
      '{ROW_ITEM, ACT_REM_RIGHT,  10'd1023, 11'd0,    1'b0, 19'd0},
      '{ROW_ITEM, ACT_REM_LEFT,   10'd3,    11'd0,    1'b0, 19'd0},
      '{ROW_ITEM, ACT_REM_LEFT,   10'd1,    11'd0,    1'b0, 19'd0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_all_results();
        write_value_limit(directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].act, int'(directed_rows[i].pos),
                  int'(directed_rows[i].value), directed_rows[i].typed,
                  directed_rows[i].count, pick_gap(1'b0));
      end
    end

    while (items_sent < TARGET_ITEMS) run_window_phase();

    wait_all_results();
    repeat (64) @(posedge clk_i);
    if (expected_counts.size() != 0) begin
      report_mismatch("results missing", '0, COUNT_W'(expected_counts.size()));
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/swic_pkg.sv
rtl/swic_ram.sv
rtl/swic_tree_engine.sv
rtl/sliding_window_inversion_counter.sv
rtl/swic_checker.sv
tb/tb_top.sv
